FILE: rtl/core/dsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_pkg: shared types and tables for the date string parser
// Token kinds, the token record passed from lexer to grammar, and the
// fixed name table used to classify words.
// ----------------------------------------------------------------------------
package dsp_pkg;

    localparam int WORD_CHARS  = 9;
    localparam int NEST_BITS   = 4;
    localparam int NUMBER_BITS = 20;

    localparam int WLEN_W     = $clog2(WORD_CHARS + 2);
    localparam int WIDX_W     = $clog2(WORD_CHARS);
    localparam int KEY_W      = 8 * 16;
    localparam int FIFO_DEPTH = 4;
    localparam int RESULT_W   = 56;
    localparam int ZONE_W     = 12;

    typedef enum logic [3:0] {
        TK_ERR, TK_WDAY, TK_MON, TK_NUM, TK_END, TK_COLON, TK_MINUS, TK_SLASH,
        TK_AMPM, TK_PLUS, TK_TZ, TK_DST, TK_DSTTZ
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t              kind;
        logic [NUMBER_BITS-1:0] val;
    } tok_t;

    function automatic tok_t mk_tok(input tok_kind_t kind, input int val);
        tok_t t;
        t.kind = kind;
        t.val  = NUMBER_BITS'(val);
        return t;
    endfunction

    // Word letters are stored as codes 1..26; rebuild lowercase ASCII,
    // right-justified, and match against the name list.
    function automatic tok_t word_lookup(input logic [WORD_CHARS*5-1:0] w,
                                         input logic [WLEN_W-1:0] len);
        logic [KEY_W-1:0] key;
        tok_t             t;
        key = '0;
        for (int j = 0; j < WORD_CHARS; j++) begin
            if (j < int'(len)) begin
                key = {key[KEY_W-9:0], 3'b011, w[j*5 +: 5]};
            end
        end
        t = mk_tok(TK_ERR, 0);
        if (int'(len) <= WORD_CHARS) begin
            unique case (key)
                "january":   t = mk_tok(TK_MON, 1);
                "february":  t = mk_tok(TK_MON, 2);
                "march":     t = mk_tok(TK_MON, 3);
                "april":     t = mk_tok(TK_MON, 4);
                "may":       t = mk_tok(TK_MON, 5);
                "june":      t = mk_tok(TK_MON, 6);
                "july":      t = mk_tok(TK_MON, 7);
                "august":    t = mk_tok(TK_MON, 8);
                "september": t = mk_tok(TK_MON, 9);
                "october":   t = mk_tok(TK_MON, 10);
                "november":  t = mk_tok(TK_MON, 11);
                "december":  t = mk_tok(TK_MON, 12);
                "jan":       t = mk_tok(TK_MON, 1);
                "feb":       t = mk_tok(TK_MON, 2);
                "mar":       t = mk_tok(TK_MON, 3);
                "apr":       t = mk_tok(TK_MON, 4);
                "jun":       t = mk_tok(TK_MON, 6);
                "jul":       t = mk_tok(TK_MON, 7);
                "aug":       t = mk_tok(TK_MON, 8);
                "sep":       t = mk_tok(TK_MON, 9);
                "sept":      t = mk_tok(TK_MON, 9);
                "oct":       t = mk_tok(TK_MON, 10);
                "nov":       t = mk_tok(TK_MON, 11);
                "dec":       t = mk_tok(TK_MON, 12);
                "sunday":    t = mk_tok(TK_WDAY, 1);
                "monday":    t = mk_tok(TK_WDAY, 2);
                "tuesday":   t = mk_tok(TK_WDAY, 3);
                "tues":      t = mk_tok(TK_WDAY, 3);
                "wednesday": t = mk_tok(TK_WDAY, 4);
                "wednes":    t = mk_tok(TK_WDAY, 4);
                "thursday":  t = mk_tok(TK_WDAY, 5);
                "thur":      t = mk_tok(TK_WDAY, 5);
                "thurs":     t = mk_tok(TK_WDAY, 5);
                "friday":    t = mk_tok(TK_WDAY, 6);
                "saturday":  t = mk_tok(TK_WDAY, 7);
                "sun":       t = mk_tok(TK_WDAY, 1);
                "mon":       t = mk_tok(TK_WDAY, 2);
                "tue":       t = mk_tok(TK_WDAY, 3);
                "wed":       t = mk_tok(TK_WDAY, 4);
                "thu":       t = mk_tok(TK_WDAY, 5);
                "fri":       t = mk_tok(TK_WDAY, 6);
                "sat":       t = mk_tok(TK_WDAY, 7);
                "am":        t = mk_tok(TK_AMPM, 1);
                "pm":        t = mk_tok(TK_AMPM, 2);
                "gmt":       t = mk_tok(TK_TZ, 0);
                "ut":        t = mk_tok(TK_TZ, 0);
                "utc":       t = mk_tok(TK_TZ, 0);
                "wet":       t = mk_tok(TK_TZ, 0);
                "z":         t = mk_tok(TK_TZ, 0);
                "wat":       t = mk_tok(TK_TZ, 100);
                "a":         t = mk_tok(TK_TZ, 100);
                "at":        t = mk_tok(TK_TZ, 200);
                "b":         t = mk_tok(TK_TZ, 200);
                "c":         t = mk_tok(TK_TZ, 300);
                "ast":       t = mk_tok(TK_TZ, 400);
                "d":         t = mk_tok(TK_TZ, 400);
                "est":       t = mk_tok(TK_TZ, 500);
                "e":         t = mk_tok(TK_TZ, 500);
                "cst":       t = mk_tok(TK_TZ, 600);
                "f":         t = mk_tok(TK_TZ, 600);
                "mst":       t = mk_tok(TK_TZ, 700);
                "g":         t = mk_tok(TK_TZ, 700);
                "pst":       t = mk_tok(TK_TZ, 800);
                "h":         t = mk_tok(TK_TZ, 800);
                "yst":       t = mk_tok(TK_TZ, 900);
                "i":         t = mk_tok(TK_TZ, 900);
                "ahst":      t = mk_tok(TK_TZ, 1000);
                "cat":       t = mk_tok(TK_TZ, 1000);
                "hst":       t = mk_tok(TK_TZ, 1000);
                "k":         t = mk_tok(TK_TZ, 1000);
                "nt":        t = mk_tok(TK_TZ, 1100);
                "l":         t = mk_tok(TK_TZ, 1100);
                "idlw":      t = mk_tok(TK_TZ, 1200);
                "m":         t = mk_tok(TK_TZ, 1200);
                "cet":       t = mk_tok(TK_TZ, -100);
                "fwt":       t = mk_tok(TK_TZ, -100);
                "met":       t = mk_tok(TK_TZ, -100);
                "mewt":      t = mk_tok(TK_TZ, -100);
                "swt":       t = mk_tok(TK_TZ, -100);
                "n":         t = mk_tok(TK_TZ, -100);
                "eet":       t = mk_tok(TK_TZ, -200);
                "o":         t = mk_tok(TK_TZ, -200);
                "bt":        t = mk_tok(TK_TZ, -300);
                "p":         t = mk_tok(TK_TZ, -300);
                "q":         t = mk_tok(TK_TZ, -400);
                "r":         t = mk_tok(TK_TZ, -500);
                "s":         t = mk_tok(TK_TZ, -600);
                "wast":      t = mk_tok(TK_TZ, -700);
                "t":         t = mk_tok(TK_TZ, -700);
                "cct":       t = mk_tok(TK_TZ, -800);
                "u":         t = mk_tok(TK_TZ, -800);
                "jst":       t = mk_tok(TK_TZ, -900);
                "v":         t = mk_tok(TK_TZ, -900);
                "east":      t = mk_tok(TK_TZ, -1000);
                "gst":       t = mk_tok(TK_TZ, -1000);
                "w":         t = mk_tok(TK_TZ, -1000);
                "x":         t = mk_tok(TK_TZ, -1100);
                "idle":      t = mk_tok(TK_TZ, -1200);
                "nzst":      t = mk_tok(TK_TZ, -1200);
                "nzt":       t = mk_tok(TK_TZ, -1200);
                "y":         t = mk_tok(TK_TZ, -1200);
                "bst":       t = mk_tok(TK_DSTTZ, 0);
                "adt":       t = mk_tok(TK_DSTTZ, 400);
                "edt":       t = mk_tok(TK_DSTTZ, 500);
                "cdt":       t = mk_tok(TK_DSTTZ, 600);
                "mdt":       t = mk_tok(TK_DSTTZ, 700);
                "pdt":       t = mk_tok(TK_DSTTZ, 800);
                "ydt":       t = mk_tok(TK_DSTTZ, 900);
                "hdt":       t = mk_tok(TK_DSTTZ, 1000);
                "mest":      t = mk_tok(TK_DSTTZ, -100);
                "mesz":      t = mk_tok(TK_DSTTZ, -100);
                "sst":       t = mk_tok(TK_DSTTZ, -100);
                "fst":       t = mk_tok(TK_DSTTZ, -100);
                "wadt":      t = mk_tok(TK_DSTTZ, -700);
                "eadt":      t = mk_tok(TK_DSTTZ, -1000);
                "nzdt":      t = mk_tok(TK_DSTTZ, -1200);
                "dst":       t = mk_tok(TK_DST, 0);
                default:     t = mk_tok(TK_ERR, 0);
            endcase
        end
        return t;
    endfunction

endpackage

FILE: rtl/core/dsp_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_lexer: character lexer
// Builds numbers, words and comments from characters and pushes tokens.
// ----------------------------------------------------------------------------
module dsp_lexer import dsp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       dot_is_delimiter,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       fifo_full,
    output logic       push,
    output tok_t       push_tok
);

    typedef enum logic [1:0] {L_IDLE, L_NUM, L_WORD, L_CMT} lex_mode_t;

    lex_mode_t              mode_reg, mode_next;
    logic [NEST_BITS-1:0]   depth_reg, depth_next, depth_dec;
    logic [NUMBER_BITS-1:0] acc_reg, acc_next;
    logic [4:0]             word_reg [WORD_CHARS];
    logic [WLEN_W-1:0]      wlen_reg, wlen_next;
    logic                   pend_valid_reg, pend_valid_next;
    tok_t                   pend_tok_reg, pend_tok_next;
    logic [WORD_CHARS*5-1:0] word_vec;
    logic [NUMBER_BITS+3:0] acc_mul;
    logic                   accept, digit, letter, fall, t1_v, t2_v, wr_word;
    logic [WIDX_W-1:0]      wr_idx;
    tok_t                   t1, t2;
    logic [7:0]             c;

    assign c             = s_axis_tdata;
    assign s_axis_tready = !pend_valid_reg && !fifo_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign digit         = (c >= "0") && (c <= "9");
    assign letter        = ((c | 8'h20) >= "a") && ((c | 8'h20) <= "z");
    assign depth_dec     = (depth_reg != '0) ? depth_reg - 1'b1 : depth_reg;
    assign acc_mul       = {acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                         + {{(NUMBER_BITS){1'b0}}, c[3:0]};

    always_comb begin
        for (int j = 0; j < WORD_CHARS; j++) word_vec[j*5 +: 5] = word_reg[j];
    end

    always_comb begin
        mode_next  = mode_reg;
        depth_next = depth_reg;
        acc_next   = acc_reg;
        wlen_next  = wlen_reg;
        wr_word    = 1'b0;
        wr_idx     = wlen_reg[WIDX_W-1:0];
        fall       = 1'b0;
        t1_v       = 1'b0;
        t2_v       = 1'b0;
        t1         = mk_tok(TK_ERR, 0);
        t2         = mk_tok(TK_ERR, 0);
        if (accept) begin
            unique case (mode_reg)
                L_CMT: begin
                    if (c == 8'h00) begin
                        // unterminated comment fails the string
                        t1_v = 1'b1;
                        t2_v = 1'b1;
                        t2 = mk_tok(TK_END, 0);
                        mode_next = L_IDLE;
                        depth_next = '0;
                    end else if (c == "(") begin
                        if (depth_reg != '1) depth_next = depth_reg + 1'b1;
                    end else if (c == ")") begin
                        depth_next = depth_dec;
                        if (depth_dec == '0) mode_next = L_IDLE;
                    end
                end
                L_NUM: begin
                    if (digit) begin
                        acc_next = (acc_mul[NUMBER_BITS+3:NUMBER_BITS] != '0) ? '1
                                 : acc_mul[NUMBER_BITS-1:0];
                    end else begin
                        t1_v = 1'b1;
                        t1.kind = TK_NUM;
                        t1.val = acc_reg;
                        fall = 1'b1;
                    end
                end
                L_WORD: begin
                    if (letter) begin
                        if (int'(wlen_reg) < WORD_CHARS) wr_word = 1'b1;
                        if (int'(wlen_reg) <= WORD_CHARS) wlen_next = wlen_reg + 1'b1;
                    end else if (c != ".") begin
                        t1_v = 1'b1;
                        t1 = word_lookup(word_vec, wlen_reg);
                        fall = 1'b1;
                    end
                end
                default: fall = 1'b1;
            endcase
            if (fall) begin
                mode_next = L_IDLE;
                t2_v = 1'b1;
                if (c == 8'h00) begin
                    t2 = mk_tok(TK_END, 0);
                end else if (c == ":") begin
                    t2 = mk_tok(TK_COLON, 0);
                end else if (c == "+") begin
                    t2 = mk_tok(TK_PLUS, 0);
                end else if (c == "-") begin
                    t2 = mk_tok(TK_MINUS, 0);
                end else if (c == "/") begin
                    t2 = mk_tok(TK_SLASH, 0);
                end else if (c == ".") begin
                    t2 = mk_tok(TK_SLASH, 0);
                    t2_v = dot_is_delimiter;
                end else if (c == " " || c == 8'h0A || c == 8'h0D || c == 8'h09
                             || c == ",") begin
                    t2_v = 1'b0;
                end else if (c == "(") begin
                    t2_v = 1'b0;
                    mode_next = L_CMT;
                    depth_next = NEST_BITS'(1);
                end else if (digit) begin
                    t2_v = 1'b0;
                    mode_next = L_NUM;
                    acc_next = NUMBER_BITS'(c[3:0]);
                end else if (letter) begin
                    t2_v = 1'b0;
                    mode_next = L_WORD;
                    wr_word = 1'b1;
                    wr_idx = '0;
                    wlen_next = WLEN_W'(1);
                end
            end
        end
    end

    // drain a held second token before taking the next character
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_tok_next   = pend_tok_reg;
        push            = 1'b0;
        push_tok        = t1_v ? t1 : t2;
        if (pend_valid_reg) begin
            push_tok = pend_tok_reg;
            if (!fifo_full) begin
                push = 1'b1;
                pend_valid_next = 1'b0;
            end
        end else if (t1_v || t2_v) begin
            push = 1'b1;
            if (t1_v && t2_v) begin
                pend_valid_next = 1'b1;
                pend_tok_next = t2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= L_IDLE;
            depth_reg      <= '0;
            acc_reg        <= '0;
            wlen_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            mode_reg       <= mode_next;
            depth_reg      <= depth_next;
            acc_reg        <= acc_next;
            wlen_reg       <= wlen_next;
            pend_valid_reg <= pend_valid_next;
        end
        pend_tok_reg <= pend_tok_next;
        if (wr_word) word_reg[wr_idx] <= c[4:0];
    end

endmodule

FILE: rtl/core/dsp_token_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_token_fifo: token queue
// Small queue between lexer and grammar.
// ----------------------------------------------------------------------------
module dsp_token_fifo import dsp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  tok_t push_tok,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output tok_t head_tok
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    tok_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [PTR_W:0]   cnt_reg;

    assign full       = (cnt_reg == (PTR_W+1)'(FIFO_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_tok   = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
        if (push) mem[wr_reg] <= push_tok;
    end

endmodule

FILE: rtl/core/dsp_grammar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_grammar: grammar machine and result stage
// Consumes one token step per cycle while a token waits and no result is held; fills date fields, checks and emits.
// ----------------------------------------------------------------------------
module dsp_grammar import dsp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                allow_missing_year,
    input  logic                head_valid,
    input  tok_t                head_tok,
    output logic                pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [RESULT_W-1:0] m_axis_tdata
);

    typedef enum logic [4:0] {
        G_TOP, G_MON, G_MON_D, G_MON_DN, G_NUM, G_NUM_MON, G_CAL1, G_CAL_DM,
        G_CAL_DMY, G_CAL2, G_CAL3, G_T_MIN, G_T_AFT, G_T_SEC, G_T_SUF,
        G_T_OFFP, G_T_OFFM, G_T_TZ
    } gram_state_t;

    localparam logic [NUMBER_BITS-1:0] OFF_MAX = NUMBER_BITS'(2047);

    gram_state_t            st_reg, st_next;
    logic [NUMBER_BITS-1:0] n0_reg, n0_next, n1_reg, n1_next;
    logic [NUMBER_BITS-1:0] year_reg, year_next, mon_reg, mon_next, day_reg, day_next;
    logic [NUMBER_BITS-1:0] hr_reg, hr_next, min_reg, min_next, sec_reg, sec_next;
    logic [2:0]             wday_reg, wday_next;
    logic [1:0]             ampm_reg, ampm_next;
    logic signed [ZONE_W-1:0] zone_reg, zone_next;
    logic                   ys_reg, ys_next, zs_reg, zs_next, err_reg, err_next;
    logic                   done_reg, done_next, fin_reg, fin_next;
    logic                   mv_reg, mv_next;
    logic [RESULT_W-1:0]    md_reg, md_next;

    tok_kind_t              k;
    logic [NUMBER_BITS-1:0] v;
    logic                   active, redo, sep, ymd, mdy, out_load;
    logic [10:0]            off_sat;

    // result path
    logic                   ok;
    logic [31:0]            yr32;
    logic [NUMBER_BITS-1:0] hr_fin;
    logic [10:0]            zmag;
    logic [23:0]            zprod;
    logic [4:0]             zq;
    logic [10:0]            zrem;
    logic [4:0]             zh;

    assign k        = head_tok.kind;
    assign v        = head_tok.val;
    assign active   = head_valid && !fin_reg;
    assign sep      = (k == TK_MINUS) || (k == TK_SLASH);
    assign off_sat  = (v > OFF_MAX) ? 11'd2047 : v[10:0];
    assign ymd      = (n0_reg > NUMBER_BITS'(12))
                   || (n1_reg >= NUMBER_BITS'(1) && n1_reg <= NUMBER_BITS'(12)
                       && v >= NUMBER_BITS'(1) && v <= NUMBER_BITS'(31));
    assign mdy      = (n0_reg >= NUMBER_BITS'(1) && n0_reg <= NUMBER_BITS'(12)
                       && n1_reg >= NUMBER_BITS'(1) && n1_reg <= NUMBER_BITS'(31))
                   || (v > NUMBER_BITS'(31));
    assign out_load = fin_reg && (!mv_reg || m_axis_tready);
    assign pop      = active && !redo;

    always_comb begin
        st_next   = st_reg;
        n0_next   = n0_reg;
        n1_next   = n1_reg;
        year_next = year_reg;
        mon_next  = mon_reg;
        day_next  = day_reg;
        hr_next   = hr_reg;
        min_next  = min_reg;
        sec_next  = sec_reg;
        wday_next = wday_reg;
        ampm_next = ampm_reg;
        zone_next = zone_reg;
        ys_next   = ys_reg;
        zs_next   = zs_reg;
        err_next  = err_reg;
        done_next = done_reg;
        fin_next  = fin_reg;
        redo      = 1'b0;
        if (active && !err_reg) begin
            if (k == TK_ERR) begin
                err_next = 1'b1;
            end else begin
                unique case (st_reg)
                    G_TOP: begin
                        if (k == TK_END) done_next = 1'b1;
                        else if (k == TK_MINUS) st_next = G_TOP;
                        else if (k == TK_WDAY) wday_next = v[2:0];
                        else if (k == TK_MON) begin
                            mon_next = v;
                            st_next = G_MON;
                        end else if (k == TK_NUM) begin
                            n0_next = v;
                            st_next = G_NUM;
                        end else err_next = 1'b1;
                    end
                    G_MON: begin
                        if (k == TK_NUM) begin
                            day_next = v;
                            st_next = G_MON_D;
                        end else begin
                            st_next = G_TOP;
                            redo = 1'b1;
                        end
                    end
                    G_MON_D: begin
                        if (k == TK_NUM) begin
                            n0_next = v;
                            st_next = G_MON_DN;
                        end else begin
                            st_next = G_TOP;
                            redo = 1'b1;
                        end
                    end
                    G_MON_DN: begin
                        if (k == TK_COLON) begin
                            hr_next = n0_reg;
                            st_next = G_T_MIN;
                        end else begin
                            year_next = n0_reg;
                            ys_next = 1'b1;
                            st_next = G_TOP;
                            redo = 1'b1;
                        end
                    end
                    G_NUM: begin
                        if (sep) st_next = G_CAL1;
                        else if (k == TK_COLON) begin
                            hr_next = n0_reg;
                            st_next = G_T_MIN;
                        end else if (k == TK_AMPM) begin
                            // standalone hour with am/pm: keep going
                            hr_next = n0_reg;
                            min_next = '0;
                            sec_next = '0;
                            ampm_next = v[1:0];
                            st_next = G_TOP;
                        end else if (k == TK_MON) begin
                            day_next = n0_reg;
                            mon_next = v;
                            st_next = G_NUM_MON;
                        end else begin
                            year_next = n0_reg;
                            ys_next = 1'b1;
                            st_next = G_TOP;
                            redo = 1'b1;
                        end
                    end
                    G_NUM_MON, G_CAL_DMY: begin
                        if (k == TK_NUM) begin
                            year_next = v;
                            ys_next = 1'b1;
                            st_next = G_TOP;
                        end else if (st_reg == G_CAL_DMY) err_next = 1'b1;
                        else begin
                            st_next = G_TOP;
                            redo = 1'b1;
                        end
                    end
                    G_CAL1: begin
                        if (k == TK_MON) begin
                            day_next = n0_reg;
                            mon_next = v;
                            st_next = G_CAL_DM;
                        end else if (k == TK_NUM) begin
                            n1_next = v;
                            st_next = G_CAL2;
                        end else err_next = 1'b1;
                    end
                    G_CAL_DM: begin
                        if (k == TK_NUM) begin
                            year_next = v;
                            ys_next = 1'b1;
                            st_next = G_TOP;
                        end else if (sep) st_next = G_CAL_DMY;
                        else begin
                            st_next = G_TOP;
                            redo = 1'b1;
                        end
                    end
                    G_CAL2: begin
                        if (sep) st_next = G_CAL3;
                        else begin
                            mon_next = n0_reg;
                            day_next = n1_reg;
                            st_next = G_TOP;
                            redo = 1'b1;
                        end
                    end
                    G_CAL3: begin
                        if (k == TK_NUM) begin
                            // resolve y/m/d against m/d/y
                            if (ymd == mdy) err_next = 1'b1;
                            else if (ymd) begin
                                year_next = n0_reg;
                                ys_next = 1'b1;
                                mon_next = n1_reg;
                                day_next = v;
                            end else begin
                                mon_next = n0_reg;
                                day_next = n1_reg;
                                year_next = v;
                                ys_next = 1'b1;
                            end
                            st_next = G_TOP;
                        end else err_next = 1'b1;
                    end
                    G_T_MIN: begin
                        if (k == TK_NUM) begin
                            min_next = v;
                            st_next = G_T_AFT;
                        end else err_next = 1'b1;
                    end
                    G_T_AFT: begin
                        if (k == TK_COLON) st_next = G_T_SEC;
                        else begin
                            sec_next = '0;
                            st_next = G_T_SUF;
                            redo = 1'b1;
                        end
                    end
                    G_T_SEC: begin
                        if (k == TK_NUM) begin
                            sec_next = v;
                            st_next = G_T_SUF;
                        end else err_next = 1'b1;
                    end
                    G_T_SUF: begin
                        if (k == TK_AMPM) begin
                            ampm_next = v[1:0];
                            st_next = G_TOP;
                        end else if (k == TK_PLUS) st_next = G_T_OFFP;
                        else if (k == TK_MINUS) st_next = G_T_OFFM;
                        else if (k == TK_TZ || k == TK_DSTTZ) begin
                            zone_next = v[ZONE_W-1:0];
                            zs_next = 1'b1;
                            st_next = (k == TK_TZ) ? G_T_TZ : G_TOP;
                        end else begin
                            st_next = G_TOP;
                            redo = 1'b1;
                        end
                    end
                    G_T_OFFP, G_T_OFFM: begin
                        if (k == TK_NUM) begin
                            zone_next = (st_reg == G_T_OFFM) ? {1'b0, off_sat}
                                                             : -{1'b0, off_sat};
                            zs_next = 1'b1;
                            st_next = G_TOP;
                        end else err_next = 1'b1;
                    end
                    G_T_TZ: begin
                        if (zone_reg == '0 && k == TK_PLUS) st_next = G_T_OFFP;
                        else if (zone_reg == '0 && k == TK_MINUS) st_next = G_T_OFFM;
                        else if (k == TK_DST) begin
                            zone_next = zone_reg + ZONE_W'(100);
                            st_next = G_TOP;
                        end else begin
                            st_next = G_TOP;
                            redo = 1'b1;
                        end
                    end
                    default: err_next = 1'b1;
                endcase
            end
        end
        if (pop && k == TK_END) fin_next = 1'b1;
    end

    // checks, am/pm folding and zone hours for the finished string
    always_comb begin
        ok     = done_reg && !err_reg;
        yr32   = {{(32-NUMBER_BITS){1'b0}}, year_reg};
        hr_fin = hr_reg;
        zmag   = zone_reg[ZONE_W-1] ? 11'(-zone_reg) : zone_reg[10:0];
        zprod  = 24'(zmag) * 24'd5243;
        zq     = zprod[23:19];
        zrem   = zmag - 11'(zq * 7'd100);
        zh     = zone_reg[ZONE_W-1] ? 5'(-zq) : zq;
        if (ok) begin
            if (!ys_reg && allow_missing_year) yr32 = '0;
            else begin
                if (!ys_reg || mon_reg < NUMBER_BITS'(1) || mon_reg > NUMBER_BITS'(12)
                    || day_reg < NUMBER_BITS'(1) || day_reg > NUMBER_BITS'(31)
                    || hr_reg > NUMBER_BITS'(23) || min_reg > NUMBER_BITS'(59)
                    || sec_reg > NUMBER_BITS'(59)) ok = 1'b0;
                if (zs_reg && (zone_reg < -ZONE_W'(1200) || zone_reg > ZONE_W'(1200)
                               || zrem != '0)) ok = 1'b0;
                if (yr32 <= 32'd99) yr32 = yr32 + 32'd1900;
            end
        end
        if (ok && ampm_reg != 2'd0) begin
            if (hr_reg > NUMBER_BITS'(12)) ok = 1'b0;
            else if (hr_reg < NUMBER_BITS'(12)) begin
                if (ampm_reg == 2'd2) hr_fin = hr_reg + NUMBER_BITS'(12);
            end else if (ampm_reg == 2'd1) hr_fin = '0;
        end
        md_next = md_reg;
        mv_next = m_axis_tready ? 1'b0 : mv_reg;
        if (out_load) begin
            mv_next = 1'b1;
            md_next = '0;
            if (ok) begin
                md_next = {zs_reg ? zh : 5'd0, zs_reg, wday_reg, sec_reg[5:0],
                           min_reg[5:0], hr_fin[4:0], day_reg[4:0], mon_reg[3:0],
                           yr32[19:0], 1'b1};
            end
        end
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = md_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || out_load) begin
            st_reg   <= G_TOP;
            n0_reg   <= '0;
            n1_reg   <= '0;
            year_reg <= '0;
            mon_reg  <= '0;
            day_reg  <= '0;
            hr_reg   <= '0;
            min_reg  <= '0;
            sec_reg  <= '0;
            wday_reg <= '0;
            ampm_reg <= '0;
            zone_reg <= '0;
            ys_reg   <= 1'b0;
            zs_reg   <= 1'b0;
            err_reg  <= 1'b0;
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end else begin
            st_reg   <= st_next;
            n0_reg   <= n0_next;
            n1_reg   <= n1_next;
            year_reg <= year_next;
            mon_reg  <= mon_next;
            day_reg  <= day_next;
            hr_reg   <= hr_next;
            min_reg  <= min_next;
            sec_reg  <= sec_next;
            wday_reg <= wday_next;
            ampm_reg <= ampm_next;
            zone_reg <= zone_next;
            ys_reg   <= ys_next;
            zs_reg   <= zs_next;
            err_reg  <= err_next;
            done_reg <= done_next;
            fin_reg  <= fin_next;
        end
        if (!aresetn) mv_reg <= 1'b0;
        else mv_reg <= mv_next;
        md_reg <= md_next;
    end

endmodule

FILE: rtl/core/date_string_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_string_parser: lenient date text parser
// Characters in, one parsed and checked date record out per string.
// ----------------------------------------------------------------------------
// The block takes one character per transaction and emits one result
// transaction when the string's terminating code 0 arrives. A character that
// closes a number or word and is itself punctuation or the terminator yields
// two tokens for the 4-entry token queue, and the lexer takes no new character
// until the second is pushed. The grammar machine takes one step per token,
// plus one step each time a token is re-examined in a new state, and then
// checks and loads the result register.
// The lexer keeps accepting characters while the grammar works or while a
// finished result waits on m_axis_tready, until the token queue fills.
// Configuration writes must be issued only while the block is idle.
module date_string_parser import dsp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration: 0 dot_is_delimiter, 1 allow_missing_year
    input  logic                cfg_wen,
    input  logic                cfg_addr,
    input  logic                cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] char_code
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [0] parse_ok, [20:1] year, [24:21] month, [29:25] day, [34:30] hours,
    // [40:35] minutes, [46:41] seconds, [49:47] weekday, [50] zone_present,
    // [55:51] zone_hours
    output logic [RESULT_W-1:0] m_axis_tdata
);

    localparam logic CFG_DOT  = 1'b0;
    localparam logic CFG_YEAR = 1'b1;

    logic dot_reg, year_cfg_reg;
    logic fifo_full, push, pop, head_valid;
    tok_t push_tok, head_tok;

    // hold the two mode bits; the user must write them only between strings, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg      <= 1'b0;
            year_cfg_reg <= 1'b0;
        end else if (cfg_wen) begin
            case (cfg_addr)
                CFG_DOT:  dot_reg <= cfg_wdata;
                CFG_YEAR: year_cfg_reg <= cfg_wdata;
                default:  dot_reg <= dot_reg;
            endcase
        end
    end

    // front: classify characters into tokens
    dsp_lexer u_lexer (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .dot_is_delimiter (dot_reg),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .fifo_full        (fifo_full),
        .push             (push),
        .push_tok         (push_tok)
    );

    // decouple lexer and grammar so each stalls on its own
    dsp_token_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_tok   (push_tok),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_tok   (head_tok)
    );

    // back: grammar, checks and result register
    dsp_grammar u_grammar (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .allow_missing_year (year_cfg_reg),
        .head_valid         (head_valid),
        .head_tok           (head_tok),
        .pop                (pop),
        .m_axis_tvalid      (m_axis_tvalid),
        .m_axis_tready      (m_axis_tready),
        .m_axis_tdata       (m_axis_tdata)
    );

endmodule

FILE: rtl/core/dsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_checker: port-level checks for the date string parser
// Watches the result channel over time.
// ----------------------------------------------------------------------------
module dsp_checker import dsp_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [RESULT_W-1:0] m_axis_tdata
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[RESULT_W-1:1] == '0)
        else $error("failed parse carries nonzero fields");

    a_zone_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[50] |-> m_axis_tdata[55:51] == 5'd0)
        else $error("zone hours without zone");

endmodule

bind date_string_parser dsp_checker u_dsp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/sv/date_parse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_parse_checker: result predictor and scoreboard for the date parser
// Watches the character and result channels and the register port, predicts
// each date record from the accepted characters, and compares records field
// by field in order.
// ----------------------------------------------------------------------------
module date_parse_checker import dsp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wen,
    input  logic                cfg_addr,
    input  logic                cfg_wdata,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [RESULT_W-1:0] m_tdata,
    output int                  err_count,
    output int                  pending,
    output int                  checked
);

    typedef enum int { LX_IDLE, LX_NUM, LX_WORD, LX_CMT } lex_mode_e;
    typedef enum int {
        GS_TOP, GS_MON, GS_MON_D, GS_MON_DN, GS_NUM, GS_NUM_MON, GS_CAL1, GS_CAL_DM,
        GS_CAL_DMY, GS_CAL2, GS_CAL3, GS_T_MIN, GS_T_AFT, GS_T_SEC, GS_T_SUF,
        GS_T_OFFP, GS_T_OFFM, GS_T_TZ
    } gram_state_e;

    localparam int NUM_SAT   = (1 << NUMBER_BITS) - 1;
    localparam int DEPTH_SAT = (1 << NEST_BITS) - 1;
    localparam int FIELD_W[10] = '{1, 20, 4, 5, 5, 6, 6, 3, 1, 5};
    localparam string FIELD_NAME[10] = '{"parse_ok", "year", "month", "day", "hours",
        "minutes", "seconds", "weekday", "zone_present", "zone_hours"};

    tok_kind_t   name_kind[string];
    int          name_val[string];

    logic [RESULT_W-1:0] date_q[$];

    bit          dot_sep, year_optional;
    lex_mode_e   lmode;
    gram_state_e gstate;
    int          depth, wlen;
    int unsigned accum;
    byte         wch[WORD_CHARS];
    int unsigned saved[3];
    bit          year_set, zone_set, err_flag, done_flag;
    int unsigned f_year, f_month, f_day, f_hours, f_minutes, f_seconds, f_wday, f_ampm;
    int          zone;
    int          mismatches;

    task automatic add_name(string s, tok_kind_t k, int v);
        name_kind[s] = k;
        name_val[s]  = v;
    endtask

    initial begin
        add_name("january", TK_MON, 1);  add_name("february", TK_MON, 2);
        add_name("march", TK_MON, 3);    add_name("april", TK_MON, 4);
        add_name("may", TK_MON, 5);      add_name("june", TK_MON, 6);
        add_name("july", TK_MON, 7);     add_name("august", TK_MON, 8);
        add_name("september", TK_MON, 9); add_name("october", TK_MON, 10);
        add_name("november", TK_MON, 11); add_name("december", TK_MON, 12);
        add_name("jan", TK_MON, 1);  add_name("feb", TK_MON, 2);  add_name("mar", TK_MON, 3);
        add_name("apr", TK_MON, 4);  add_name("jun", TK_MON, 6);  add_name("jul", TK_MON, 7);
        add_name("aug", TK_MON, 8);  add_name("sep", TK_MON, 9);  add_name("sept", TK_MON, 9);
        add_name("oct", TK_MON, 10); add_name("nov", TK_MON, 11); add_name("dec", TK_MON, 12);
        add_name("sunday", TK_WDAY, 1);  add_name("monday", TK_WDAY, 2);
        add_name("tuesday", TK_WDAY, 3); add_name("tues", TK_WDAY, 3);
        add_name("wednesday", TK_WDAY, 4); add_name("wednes", TK_WDAY, 4);
        add_name("thursday", TK_WDAY, 5); add_name("thur", TK_WDAY, 5);
        add_name("thurs", TK_WDAY, 5);   add_name("friday", TK_WDAY, 6);
        add_name("saturday", TK_WDAY, 7);
        add_name("sun", TK_WDAY, 1); add_name("mon", TK_WDAY, 2); add_name("tue", TK_WDAY, 3);
        add_name("wed", TK_WDAY, 4); add_name("thu", TK_WDAY, 5); add_name("fri", TK_WDAY, 6);
        add_name("sat", TK_WDAY, 7);
        add_name("am", TK_AMPM, 1); add_name("pm", TK_AMPM, 2);
        add_name("gmt", TK_TZ, 0); add_name("ut", TK_TZ, 0); add_name("utc", TK_TZ, 0);
        add_name("wet", TK_TZ, 0); add_name("z", TK_TZ, 0);
        add_name("wat", TK_TZ, 100); add_name("a", TK_TZ, 100);
        add_name("at", TK_TZ, 200);  add_name("b", TK_TZ, 200); add_name("c", TK_TZ, 300);
        add_name("ast", TK_TZ, 400); add_name("d", TK_TZ, 400);
        add_name("est", TK_TZ, 500); add_name("e", TK_TZ, 500);
        add_name("cst", TK_TZ, 600); add_name("f", TK_TZ, 600);
        add_name("mst", TK_TZ, 700); add_name("g", TK_TZ, 700);
        add_name("pst", TK_TZ, 800); add_name("h", TK_TZ, 800);
        add_name("yst", TK_TZ, 900); add_name("i", TK_TZ, 900);
        add_name("ahst", TK_TZ, 1000); add_name("cat", TK_TZ, 1000);
        add_name("hst", TK_TZ, 1000);  add_name("k", TK_TZ, 1000);
        add_name("nt", TK_TZ, 1100);   add_name("l", TK_TZ, 1100);
        add_name("idlw", TK_TZ, 1200); add_name("m", TK_TZ, 1200);
        add_name("cet", TK_TZ, -100); add_name("fwt", TK_TZ, -100);
        add_name("met", TK_TZ, -100); add_name("mewt", TK_TZ, -100);
        add_name("swt", TK_TZ, -100); add_name("n", TK_TZ, -100);
        add_name("eet", TK_TZ, -200); add_name("o", TK_TZ, -200);
        add_name("bt", TK_TZ, -300);  add_name("p", TK_TZ, -300);
        add_name("q", TK_TZ, -400);   add_name("r", TK_TZ, -500); add_name("s", TK_TZ, -600);
        add_name("wast", TK_TZ, -700); add_name("t", TK_TZ, -700);
        add_name("cct", TK_TZ, -800);  add_name("u", TK_TZ, -800);
        add_name("jst", TK_TZ, -900);  add_name("v", TK_TZ, -900);
        add_name("east", TK_TZ, -1000); add_name("gst", TK_TZ, -1000);
        add_name("w", TK_TZ, -1000);   add_name("x", TK_TZ, -1100);
        add_name("idle", TK_TZ, -1200); add_name("nzst", TK_TZ, -1200);
        add_name("nzt", TK_TZ, -1200);  add_name("y", TK_TZ, -1200);
        add_name("bst", TK_DSTTZ, 0);   add_name("adt", TK_DSTTZ, 400);
        add_name("edt", TK_DSTTZ, 500); add_name("cdt", TK_DSTTZ, 600);
        add_name("mdt", TK_DSTTZ, 700); add_name("pdt", TK_DSTTZ, 800);
        add_name("ydt", TK_DSTTZ, 900); add_name("hdt", TK_DSTTZ, 1000);
        add_name("mest", TK_DSTTZ, -100); add_name("mesz", TK_DSTTZ, -100);
        add_name("sst", TK_DSTTZ, -100);  add_name("fst", TK_DSTTZ, -100);
        add_name("wadt", TK_DSTTZ, -700); add_name("eadt", TK_DSTTZ, -1000);
        add_name("nzdt", TK_DSTTZ, -1200);
        add_name("dst", TK_DST, 0);
    end

    function automatic bit within_range(int unsigned v, int unsigned lo, int unsigned hi);
        return v >= lo && v <= hi;
    endfunction

    task automatic clear_parse();
        lmode = LX_IDLE; gstate = GS_TOP; depth = 0; accum = 0; wlen = 0;
        foreach (wch[j]) wch[j] = 0;
        foreach (saved[j]) saved[j] = 0;
        year_set = 0; zone_set = 0; err_flag = 0; done_flag = 0;
        f_year = 0; f_month = 0; f_day = 0; f_hours = 0; f_minutes = 0;
        f_seconds = 0; f_wday = 0; f_ampm = 0; zone = 0;
    endtask

    task automatic set_year(int unsigned v);
        f_year = v; year_set = 1;
    endtask

    // Advance the grammar by one token; some states hand the token on to the top
    // level or to the time-suffix state for another look.
    task automatic grammar_token(tok_kind_t k, int v);
        bit redo;
        bit sep;
        bit ymd, mdy;
        int unsigned n1, n2, uv, m;
        redo = 1;
        uv = v;
        if (err_flag || done_flag) return;
        if (k == TK_ERR) begin
            err_flag = 1;
            return;
        end
        while (redo && !err_flag) begin
            n1 = saved[0]; n2 = saved[1];
            sep = (k == TK_MINUS || k == TK_SLASH);
            redo = 0;
            case (gstate)
                GS_TOP: begin
                    if (k == TK_END) done_flag = 1;
                    else if (k == TK_MINUS) ;
                    else if (k == TK_WDAY) f_wday = uv;
                    else if (k == TK_MON) begin f_month = uv; gstate = GS_MON; end
                    else if (k == TK_NUM) begin saved[0] = uv; gstate = GS_NUM; end
                    else err_flag = 1;
                end
                GS_MON: begin
                    if (k == TK_NUM) begin f_day = uv; gstate = GS_MON_D; end
                    else begin gstate = GS_TOP; redo = 1; end
                end
                GS_MON_D: begin
                    if (k == TK_NUM) begin saved[0] = uv; gstate = GS_MON_DN; end
                    else begin gstate = GS_TOP; redo = 1; end
                end
                GS_MON_DN: begin
                    if (k == TK_COLON) begin f_hours = n1; gstate = GS_T_MIN; end
                    else begin set_year(n1); gstate = GS_TOP; redo = 1; end
                end
                GS_NUM: begin
                    if (sep) gstate = GS_CAL1;
                    else if (k == TK_COLON) begin f_hours = n1; gstate = GS_T_MIN; end
                    else if (k == TK_AMPM) begin
                        // a bare hour with am/pm: keep parsing
                        f_hours = n1; f_minutes = 0; f_seconds = 0; f_ampm = uv;
                        gstate = GS_TOP;
                    end else if (k == TK_MON) begin
                        f_day = n1; f_month = uv; gstate = GS_NUM_MON;
                    end else begin set_year(n1); gstate = GS_TOP; redo = 1; end
                end
                GS_NUM_MON, GS_CAL_DMY: begin
                    if (k == TK_NUM) begin set_year(uv); gstate = GS_TOP; end
                    else if (gstate == GS_CAL_DMY) err_flag = 1;
                    else begin gstate = GS_TOP; redo = 1; end
                end
                GS_CAL1: begin
                    if (k == TK_MON) begin f_day = n1; f_month = uv; gstate = GS_CAL_DM; end
                    else if (k == TK_NUM) begin saved[1] = uv; gstate = GS_CAL2; end
                    else err_flag = 1;
                end
                GS_CAL_DM: begin
                    if (k == TK_NUM) begin set_year(uv); gstate = GS_TOP; end
                    else if (sep) gstate = GS_CAL_DMY;
                    else begin gstate = GS_TOP; redo = 1; end
                end
                GS_CAL2: begin
                    if (sep) gstate = GS_CAL3;
                    else begin f_month = n1; f_day = n2; gstate = GS_TOP; redo = 1; end
                end
                GS_CAL3: begin
                    if (k == TK_NUM) begin
                        ymd = n1 > 12 || (within_range(n2, 1, 12) && within_range(uv, 1, 31));
                        mdy = (within_range(n1, 1, 12) && within_range(n2, 1, 31)) || uv > 31;
                        if (ymd == mdy) err_flag = 1;
                        else if (ymd) begin set_year(n1); f_month = n2; f_day = uv; end
                        else begin f_month = n1; f_day = n2; set_year(uv); end
                        gstate = GS_TOP;
                    end else err_flag = 1;
                end
                GS_T_MIN: begin
                    if (k == TK_NUM) begin f_minutes = uv; gstate = GS_T_AFT; end
                    else err_flag = 1;
                end
                GS_T_AFT: begin
                    if (k == TK_COLON) gstate = GS_T_SEC;
                    else begin f_seconds = 0; gstate = GS_T_SUF; redo = 1; end
                end
                GS_T_SEC: begin
                    if (k == TK_NUM) begin f_seconds = uv; gstate = GS_T_SUF; end
                    else err_flag = 1;
                end
                GS_T_SUF: begin
                    if (k == TK_AMPM) begin f_ampm = uv; gstate = GS_TOP; end
                    else if (k == TK_PLUS) gstate = GS_T_OFFP;
                    else if (k == TK_MINUS) gstate = GS_T_OFFM;
                    else if (k == TK_TZ || k == TK_DSTTZ) begin
                        zone = v; zone_set = 1;
                        gstate = (k == TK_TZ) ? GS_T_TZ : GS_TOP;
                    end else begin gstate = GS_TOP; redo = 1; end
                end
                GS_T_OFFP, GS_T_OFFM: begin
                    if (k == TK_NUM) begin
                        m = (uv > 2047) ? 2047 : uv;
                        zone = (gstate == GS_T_OFFM) ? int'(m) : -int'(m);
                        zone_set = 1;
                        gstate = GS_TOP;
                    end else err_flag = 1;
                end
                GS_T_TZ: begin
                    if (zone == 0 && k == TK_PLUS) gstate = GS_T_OFFP;
                    else if (zone == 0 && k == TK_MINUS) gstate = GS_T_OFFM;
                    else if (k == TK_DST) begin zone += 100; gstate = GS_TOP; end
                    else begin gstate = GS_TOP; redo = 1; end
                end
                default: err_flag = 1;
            endcase
        end
    endtask

    task automatic close_word();
        string w;
        w = "";
        for (int j = 0; j < wlen && j < WORD_CHARS; j++)
            w = $sformatf("%s%c", w, 8'(96 + wch[j]));
        if (wlen <= WORD_CHARS && name_kind.exists(w))
            grammar_token(name_kind[w], name_val[w]);
        else
            grammar_token(TK_ERR, 0);
    endtask

    // Check the parsed fields and queue the packed date record.
    task automatic emit_record();
        bit          ok;
        int unsigned yr, hr;
        int          zh;
        ok = done_flag && !err_flag;
        yr = f_year; hr = f_hours; zh = 0;
        if (ok) begin
            if (!year_set && year_optional) yr = 0;
            else begin
                if (!year_set || !within_range(f_month, 1, 12) || !within_range(f_day, 1, 31)
                    || hr > 23 || f_minutes > 59 || f_seconds > 59) ok = 0;
                if (zone_set && (zone < -1200 || zone > 1200 || zone % 100 != 0)) ok = 0;
                if (yr <= 99) yr += 1900;
            end
        end
        if (ok && f_ampm != 0) begin
            if (hr > 12) ok = 0;
            else if (hr < 12) begin
                if (f_ampm == 2) hr += 12;
            end else if (f_ampm == 1) hr = 0;
        end
        if (ok) begin
            if (zone_set) zh = zone / 100;
            date_q.push_back({5'(zh), zone_set, 3'(f_wday), 6'(f_seconds), 6'(f_minutes),
                              5'(hr), 5'(f_day), 4'(f_month), 20'(yr), 1'b1});
        end else
            date_q.push_back('0);
        clear_parse();
    endtask

    task automatic take_char(byte unsigned c);
        bit      digit, letter;
        longint  t;
        digit  = c >= "0" && c <= "9";
        letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        if (lmode == LX_CMT) begin
            if (c == 0) begin
                grammar_token(TK_ERR, 0);
                emit_record();
            end else if (c == "(") begin
                if (depth < DEPTH_SAT) depth++;
            end else if (c == ")") begin
                if (depth > 0) depth--;
                if (depth == 0) lmode = LX_IDLE;
            end
            return;
        end
        if (lmode == LX_NUM) begin
            if (digit) begin
                t = longint'(accum) * 10 + (c - "0");
                accum = (t > NUM_SAT) ? NUM_SAT : int'(t);
                return;
            end
            grammar_token(TK_NUM, int'(accum));
            lmode = LX_IDLE;
        end else if (lmode == LX_WORD) begin
            if (letter) begin
                if (wlen < WORD_CHARS) wch[wlen] = ((c | 8'h20) - "a" + 1);
                if (wlen <= WORD_CHARS) wlen++;
                return;
            end
            if (c == ".") return;
            close_word();
            lmode = LX_IDLE;
        end
        if (c == 0) begin
            grammar_token(TK_END, 0);
            emit_record();
        end
        else if (c == ":") grammar_token(TK_COLON, 0);
        else if (c == "+") grammar_token(TK_PLUS, 0);
        else if (c == "-") grammar_token(TK_MINUS, 0);
        else if (c == "/") grammar_token(TK_SLASH, 0);
        else if (c == ".") begin
            if (dot_sep) grammar_token(TK_SLASH, 0);
        end
        else if (c == " " || c == 8'h0a || c == 8'h0d || c == 8'h09 || c == ",") ;
        else if (c == "(") begin lmode = LX_CMT; depth = 1; end
        else if (digit) begin lmode = LX_NUM; accum = c - "0"; end
        else if (letter) begin
            lmode = LX_WORD;
            wch[0] = ((c | 8'h20) - "a" + 1);
            wlen = 1;
        end else grammar_token(TK_ERR, 0);
    endtask

    task automatic compare_record(logic [RESULT_W-1:0] got);
        logic [RESULT_W-1:0] want;
        int                  lsb;
        bit                  bad;
        if (date_q.size() == 0) begin
            err_count++;
            if (mismatches++ < 10)
                $display("[%0t] date record with none expected: %h", $realtime, got);
            return;
        end
        want = date_q.pop_front();
        checked++;
        lsb = 0;
        bad = 0;
        for (int f = 0; f < 10; f++) begin
            if (((want ^ got) >> lsb) & ((56'd1 << FIELD_W[f]) - 1)) begin
                if (mismatches < 10)
                    $display("[%0t] %s: expected %0d, got %0d", $realtime, FIELD_NAME[f],
                             (want >> lsb) & ((56'd1 << FIELD_W[f]) - 1),
                             (got >> lsb) & ((56'd1 << FIELD_W[f]) - 1));
                bad = 1;
            end
            lsb += FIELD_W[f];
        end
        if (bad) begin
            mismatches++;
            err_count++;
        end
    endtask

    initial begin
        err_count = 0; checked = 0; mismatches = 0;
        dot_sep = 0; year_optional = 0;
        clear_parse();
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            dot_sep = 0;
            year_optional = 0;
            clear_parse();
            date_q.delete();
        end else begin
            if (cfg_wen) begin
                if (cfg_addr == 1'b0) dot_sep = cfg_wdata;
                else year_optional = cfg_wdata;
            end
            if (m_tvalid && m_tready) compare_record(m_tdata);
            if (s_tvalid && s_tready) take_char(s_tdata);
        end
        pending = date_q.size();
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: date string parser stimulus and verdict
// Feeds directed and randomly built date strings through the parser under
// several register settings with random stalls on both channels, but for one
// stretch with none; the checker predicts and compares every date record.
// ----------------------------------------------------------------------------
module testbench;
    import dsp_pkg::*;

    localparam int CFG_DOT_DELIM  = 0;
    localparam int CFG_OPT_YEAR   = 1;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_CHARS   = 450;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wen = 1'b0;
    logic                cfg_addr = 1'b0;
    logic                cfg_wdata = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [RESULT_W-1:0] m_axis_tdata;

    int err_count, pending, checked;
    int cycles = 0;
    int strings_sent = 0;
    int chars_sent = 0;
    bit stall_en = 1'b1;    // clear for a stretch with no idling at all

    byte unsigned text[$];

    string month_names[] = '{"jan", "February", "MAR", "april", "may", "jun", "July",
        "aug", "sept", "Oct", "november", "DEC"};
    string wday_names[] = '{"sun", "Monday", "tues", "wed", "thurs", "Fri", "saturday"};
    string zone_names[] = '{"gmt", "UT", "z", "est", "pdt", "cet", "nzst", "idlw", "y",
        "m", "bst", "jst", "wadt", "nzdt", "a"};

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Stall the result side at random, about 31 times in a hundred, while stalls are enabled.
    always @(negedge aclk)
        m_axis_tready <= !(stall_en && $urandom_range(99) < 31);

    date_string_parser u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wen      (cfg_wen),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    date_parse_checker u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wen  (cfg_wen),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .err_count(err_count),
        .pending  (pending),
        .checked  (checked)
    );

    // Drive one character transaction; called at a falling edge, returns at
    // one. Hold tvalid across back-to-back transactions.
    task automatic send_char(byte unsigned c);
        if (stall_en && $urandom_range(99) < 31) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = c;
        forever begin
            #1;
            if (s_axis_tready) begin
                @(negedge aclk);
                break;
            end
            @(negedge aclk);
        end
        chars_sent++;
    endtask

    // Send the built text followed by the terminating code 0.
    task automatic send_text();
        foreach (text[j]) send_char(text[j]);
        send_char(8'd0);
        s_axis_tvalid = 1'b0;
        strings_sent++;
        text.delete();
    endtask

    task automatic add_str(string s);
        for (int j = 0; j < s.len(); j++) text.push_back(s[j]);
    endtask

    task automatic send_str(string s);
        add_str(s);
        send_text();
    endtask

    // Drain before a register write: every record in, then let the block settle.
    task automatic write_reg(int idx, bit val);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wen   = 1'b1;
        cfg_addr  = idx[0];
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wen   = 1'b0;
    endtask

    task automatic add_sep();
        case ($urandom_range(7))
            0: add_str(", ");
            1: add_str("\t");
            2: add_str(" (at noon) ");
            3: add_str("  ");
            default: add_str(" ");
        endcase
    endtask

    function automatic int pick_value(int lo, int hi);
        case ($urandom_range(9))
            0: return $urandom_range(hi + 2);
            1: return $urandom_range(2000000);
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // Build a mostly well-formed date string with random content.
    task automatic build_date(bit dot_on);
        int yr, mo, dy;
        string dsep;
        yr = ($urandom_range(2) == 0) ? pick_value(0, 99) : pick_value(1900, 2100);
        mo = pick_value(1, 12);
        dy = pick_value(1, 31);
        dsep = (dot_on && $urandom_range(1)) ? "." : (($urandom_range(3) == 0) ? "-" : "/");
        if ($urandom_range(2) == 0) begin
            add_str(wday_names[$urandom_range(6)]);
            add_sep();
        end
        case ($urandom_range(5))
            0: add_str($sformatf("%s %0d %0d", month_names[(mo + 11) % 12], dy, yr));
            1: add_str($sformatf("%0d %s %0d", dy, month_names[(mo + 11) % 12], yr));
            2: add_str($sformatf("%0d%s%0d%s%0d", mo, dsep, dy, dsep, yr));
            3: add_str($sformatf("%0d%s%0d%s%0d", yr, dsep, mo, dsep, dy));
            4: add_str($sformatf("%0d%s%s%s%0d", dy, dsep, month_names[(mo + 11) % 12],
                                 dsep, yr));
            default: add_str($sformatf("%s %0d", month_names[(mo + 11) % 12], dy));
        endcase
        if ($urandom_range(3) != 0) begin
            add_sep();
            add_str($sformatf("%0d:%0d", pick_value(0, 23), pick_value(0, 59)));
            if ($urandom_range(1)) add_str($sformatf(":%0d", pick_value(0, 59)));
            case ($urandom_range(5))
                0: add_str($urandom_range(1) ? " am" : " PM");
                1: add_str($sformatf(" %s", zone_names[$urandom_range(14)]));
                2: add_str($sformatf(" %s%0d", $urandom_range(1) ? "+" : "-",
                                     $urandom_range(1) ? 100 * $urandom_range(13)
                                                       : $urandom_range(99999)));
                3: add_str($urandom_range(1) ? " gmt+0300" : " est dst");
                default: ;
            endcase
        end
        // Break a fraction of the strings with stray nonzero bytes.
        if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(3, 1))
                text.insert($urandom_range(text.size()), 8'($urandom_range(255, 1)));
        end
    endtask

    task automatic random_phase(int n_chars, bit dot_on);
        int start;
        start = chars_sent;
        while (chars_sent - start < n_chars) begin
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(12, 1)) text.push_back(8'($urandom_range(255, 1)));
            else
                build_date(dot_on);
            send_text();
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // registers at their reset values: directed cases
        send_str("");
        send_str("Tue, 3 Feb 2004 10:20:30 GMT");
        send_str("jan 5 1999 23:59:59 est dst");
        send_str("1/2/3");
        send_str("2000/1/31 12:00 am");
        send_str("13/13/2000");
        send_str("(a (nested (deep)) note) may 1 2000");
        send_str("((((((((((((((((((x)))))) june 4 2001");
        send_str("jan 1 2000 (never closed");
        send_str("jan 1 2000 #");
        send_str("99999999999 jan 1");
        send_str("septemberx 1 2000");
        send_str("jan. 3. 2000");
        send_str("5 pm jan 1 2000");
        send_str("jan 1 2000 13:00 pm");
        send_str("1-feb-2020 1:2 -99999");
        send_str("3 feb 2020 gmt+0530");
        send_str("3 feb 2020 10:00 gmt-1300");
        send_str("12/31/1999 1:00:00 nzdt");
        send_str("3 feb");
        write_reg(CFG_DOT_DELIM, 1'b1);
        send_str("1.2.2003 4:05 pm");
        write_reg(CFG_OPT_YEAR, 1'b1);
        send_str("sat 1:00 am");
        send_str("dec 32");

        // random strings over several register settings
        random_phase(RANDOM_CHARS / 5, 1'b1);
        write_reg(CFG_DOT_DELIM, 1'b0);
        random_phase(RANDOM_CHARS / 5, 1'b0);

        // hold off until every record is back, then run with no idling
        wait (pending == 0);
        @(negedge aclk);
        stall_en = 1'b0;
        random_phase(RANDOM_CHARS / 5, 1'b0);
        stall_en = 1'b1;

        write_reg(CFG_OPT_YEAR, 1'b0);
        write_reg(CFG_DOT_DELIM, 1'b1);
        random_phase(RANDOM_CHARS / 5, 1'b1);
        write_reg(CFG_DOT_DELIM, 1'b0);
        random_phase(RANDOM_CHARS / 5, 1'b0);

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Covered %0d strings (%0d characters), %0d date records checked,",
                 strings_sent, chars_sent, checked);
        $display("under all four register settings with stalls on both channels.");
        if (err_count == 0 && pending == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
